// ===== sv/tdps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdps_pkg: shared constants for the timed dose pump scheduler
// Register indexes, mode codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package tdps_pkg;

   // field widths
   localparam int SESS_W  = 16;
   localparam int SHOTS_W = 8;
   localparam int SETTLE_W = 16;
   localparam int PUMP_W  = 18;
   localparam int REL_W   = 8;
   localparam int BLINK_W = 10;
   localparam int TOG_W   = 4;
   localparam int WAIT_W  = 18;
   localparam int MODE_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SESSION_SECONDS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHOTS_PER_SESSION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_MS         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PUMP_MS           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_MS        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_MS          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_TOGGLES     = 3'd6;

   // register reset values
   localparam logic [SESS_W-1:0]   RST_SESSION_SECONDS   = 16'd46800;
   localparam logic [SHOTS_W-1:0]  RST_SHOTS_PER_SESSION = 8'd25;
   localparam logic [SETTLE_W-1:0] RST_SETTLE_MS         = 16'd5000;
   localparam logic [PUMP_W-1:0]   RST_PUMP_MS           = 18'd67500;
   localparam logic [REL_W-1:0]    RST_RELEASE_MS        = 8'd30;
   localparam logic [BLINK_W-1:0]  RST_BLINK_MS          = 10'd400;
   localparam logic [TOG_W-1:0]    RST_BLINK_TOGGLES     = 4'd7;

   // operating modes
   localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SETTLE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PUMP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SLEEP   = 3'd5;

endpackage

// ===== sv/timed_dose_pump_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_dose_pump_scheduler: cup-triggered dosing pump with session timer
// One item per millisecond tick; drives pump, LED and sleep indication.
// ----------------------------------------------------------------------------
// Each item is one millisecond tick with the cup sensor level, and each
// tick returns one result item with the LED, pump, sleep flag and seconds
// left in the session, all as they stand after that tick. A tick on which
// a full cup is removed before session end, with shots still left, also
// computes the dose interval (seconds left / shots left) in a bit-serial
// restoring divider, one quotient bit per cycle; the block then accepts
// no item until the quotient is stored. The result of such a tick is
// available right away. A single result register sits on the output: a
// new tick is accepted only when it is empty or its result item is taken
// in the same cycle, so a waiting result stalls the input. Configuration
// writes are always accepted and take effect at the next load of the
// affected counter.
// ----------------------------------------------------------------------------
module timed_dose_pump_scheduler #(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic                              clock,
   input  logic                              reset,
   // tick input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cup_present,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_led_lit,
   output logic                              rsp_pump_run,
   output logic                              rsp_asleep,
   output logic [tdps_pkg::SESS_W-1:0]       rsp_seconds_remaining,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdps_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int PRE_W = $clog2(TICKS_PER_SECOND + 1);
   localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(TICKS_PER_SECOND - 1);
   localparam int CNT_W = $clog2(tdps_pkg::SESS_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tdps_pkg::SESS_W - 1);

   // configuration registers
   logic [tdps_pkg::SESS_W-1:0]   cfg_sess_ff;
   logic [tdps_pkg::SHOTS_W-1:0]  cfg_shots_ff;
   logic [tdps_pkg::SETTLE_W-1:0] cfg_settle_ff;
   logic [tdps_pkg::PUMP_W-1:0]   cfg_pump_ff;
   logic [tdps_pkg::REL_W-1:0]    cfg_rel_ff;
   logic [tdps_pkg::BLINK_W-1:0]  cfg_blink_ff;
   logic [tdps_pkg::TOG_W-1:0]    cfg_tog_ff;

   // scheduler state
   logic [tdps_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [tdps_pkg::WAIT_W-1:0]   wait_ff, wait_in;
   logic [PRE_W-1:0]              pre_ff, pre_in;
   logic [tdps_pkg::SESS_W-1:0]   sess_ff, sess_in;
   logic [tdps_pkg::SESS_W-1:0]   intv_ff, intv_in;
   logic [tdps_pkg::SHOTS_W-1:0]  shots_ff, shots_in;
   logic                          full_ff, full_in;
   logic                          led_ff, led_in;
   logic [tdps_pkg::TOG_W-1:0]    tog_ff, tog_in;
   logic                          pump_ff, pump_in;

   // divider
   logic                          div_busy_ff;
   logic [CNT_W-1:0]              div_cnt_ff;
   logic [tdps_pkg::SESS_W-1:0]   div_dq_ff, div_dq_in;
   logic [tdps_pkg::SHOTS_W-1:0]  div_rem_ff, div_rem_in;
   logic [tdps_pkg::SHOTS_W-1:0]  div_dsr_ff;
   logic                          div_dec_ff;
   logic [tdps_pkg::SHOTS_W:0]    div_trial;
   logic                          div_ge;
   logic                          div_start;
   logic                          div_dec_in;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_led_ff, rsp_pump_ff, rsp_asleep_ff;
   logic [tdps_pkg::SESS_W-1:0]   rsp_sess_ff;

   logic                          req_fire;
   logic                          cup;
   logic [tdps_pkg::WAIT_W-1:0]   wait_dec;
   logic                          wait_zero;
   logic                          timer_runs;
   logic                          pre_wrap;
   logic                          fill;

   assign cup       = req_cup_present;
   assign req_ready = !div_busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_led_lit           = rsp_led_ff;
   assign rsp_pump_run          = rsp_pump_ff;
   assign rsp_asleep            = rsp_asleep_ff;
   assign rsp_seconds_remaining = rsp_sess_ff;

   // configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sess_ff   <= tdps_pkg::RST_SESSION_SECONDS;
         cfg_shots_ff  <= tdps_pkg::RST_SHOTS_PER_SESSION;
         cfg_settle_ff <= tdps_pkg::RST_SETTLE_MS;
         cfg_pump_ff   <= tdps_pkg::RST_PUMP_MS;
         cfg_rel_ff    <= tdps_pkg::RST_RELEASE_MS;
         cfg_blink_ff  <= tdps_pkg::RST_BLINK_MS;
         cfg_tog_ff    <= tdps_pkg::RST_BLINK_TOGGLES;
      end else if (csr_valid) begin
         unique case (csr_index)
            tdps_pkg::REG_SESSION_SECONDS:   cfg_sess_ff   <= csr_data[tdps_pkg::SESS_W-1:0];
            tdps_pkg::REG_SHOTS_PER_SESSION: cfg_shots_ff  <= csr_data[tdps_pkg::SHOTS_W-1:0];
            tdps_pkg::REG_SETTLE_MS:         cfg_settle_ff <= csr_data[tdps_pkg::SETTLE_W-1:0];
            tdps_pkg::REG_PUMP_MS:           cfg_pump_ff   <= csr_data[tdps_pkg::PUMP_W-1:0];
            tdps_pkg::REG_RELEASE_MS:        cfg_rel_ff    <= csr_data[tdps_pkg::REL_W-1:0];
            tdps_pkg::REG_BLINK_MS:          cfg_blink_ff  <= csr_data[tdps_pkg::BLINK_W-1:0];
            tdps_pkg::REG_BLINK_TOGGLES:     cfg_tog_ff    <= csr_data[tdps_pkg::TOG_W-1:0];
            default: ;
         endcase
      end
   end

   // wait timer countdown and prescaler wrap
   assign wait_dec   = (wait_ff != '0) ? wait_ff - 1'b1 : '0;
   assign wait_zero  = (wait_dec == '0);
   assign timer_runs = (mode_ff != tdps_pkg::MODE_SLEEP);
   assign pre_wrap   = (pre_ff == PRE_LAST);

   // next state for one tick
   always_comb begin
      mode_in    = mode_ff;
      wait_in    = wait_ff;
      pre_in     = pre_ff;
      sess_in    = sess_ff;
      intv_in    = intv_ff;
      shots_in   = shots_ff;
      full_in    = full_ff;
      led_in     = led_ff;
      tog_in     = tog_ff;
      pump_in    = pump_ff;
      div_start  = 1'b0;
      div_dec_in = 1'b0;
      fill       = 1'b0;

      unique case (mode_ff)
         tdps_pkg::MODE_SETTLE: begin
            wait_in = wait_dec;
            if (wait_zero) begin
               if (cup) begin
                  pump_in = 1'b1;
                  wait_in = (cfg_pump_ff == '0) ? tdps_pkg::WAIT_W'(1) : cfg_pump_ff;
                  mode_in = tdps_pkg::MODE_PUMP;
               end else begin
                  mode_in = tdps_pkg::MODE_IDLE;
               end
            end
         end
         tdps_pkg::MODE_PUMP: begin
            wait_in = wait_dec;
            if (wait_zero) begin
               pump_in = 1'b0;
               full_in = 1'b1;
               mode_in = tdps_pkg::MODE_IDLE;
            end
         end
         tdps_pkg::MODE_RELEASE: begin
            wait_in = wait_dec;
            if (wait_zero) begin
               mode_in = tdps_pkg::MODE_IDLE;
            end
         end
         tdps_pkg::MODE_BLINK: begin
            wait_in = wait_dec;
            if (wait_zero) begin
               if (tog_ff != '0) begin
                  led_in  = !led_ff;
                  tog_in  = tog_ff - 1'b1;
                  wait_in = tdps_pkg::WAIT_W'(cfg_blink_ff);
               end else begin
                  mode_in = tdps_pkg::MODE_SLEEP;
               end
            end
         end
         tdps_pkg::MODE_SLEEP: begin
            if (cup) begin
               mode_in = tdps_pkg::MODE_IDLE;
            end
         end
         default: begin
            mode_in = tdps_pkg::MODE_IDLE;
            if (sess_ff == '0) begin
               if (full_ff && !cup) begin
                  // session over: reload, then blink out or sleep
                  sess_in  = cfg_sess_ff;
                  shots_in = cfg_shots_ff;
                  intv_in  = '0;
                  full_in  = 1'b0;
                  tog_in   = cfg_tog_ff;
                  if (cfg_tog_ff != '0) begin
                     led_in  = !led_ff;
                     tog_in  = cfg_tog_ff - 1'b1;
                     wait_in = tdps_pkg::WAIT_W'(cfg_blink_ff);
                     mode_in = tdps_pkg::MODE_BLINK;
                  end else begin
                     mode_in = tdps_pkg::MODE_SLEEP;
                  end
               end else begin
                  led_in = 1'b1;
                  fill   = 1'b1;
               end
            end else begin
               if (intv_ff == '0) begin
                  led_in = 1'b1;
               end
               if (full_ff && !cup) begin
                  // cup removed: next interval from the serial divider
                  shots_in = shots_ff - 1'b1;
                  intv_in  = '0;
                  div_start = (shots_in != '0);
                  full_in  = 1'b0;
                  led_in   = 1'b0;
                  wait_in  = tdps_pkg::WAIT_W'(cfg_rel_ff);
                  mode_in  = tdps_pkg::MODE_RELEASE;
               end else begin
                  fill = 1'b1;
               end
            end
            if (fill && !full_ff && cup) begin
               wait_in = tdps_pkg::WAIT_W'(cfg_settle_ff);
               mode_in = tdps_pkg::MODE_SETTLE;
            end
         end
      endcase

      // one-second prescaler, session and interval stop at zero
      if (timer_runs) begin
         if (pre_wrap) begin
            pre_in = '0;
            if (sess_in != '0) begin
               sess_in = sess_in - 1'b1;
            end
            if (div_start) begin
               div_dec_in = 1'b1;
            end else if (intv_in != '0) begin
               intv_in = intv_in - 1'b1;
            end
         end else begin
            pre_in = pre_ff + 1'b1;
         end
      end
   end

   // restoring divider step: one quotient bit per cycle
   assign div_trial  = {div_rem_ff, div_dq_ff[tdps_pkg::SESS_W-1]};
   assign div_ge     = (div_trial >= {1'b0, div_dsr_ff});
   assign div_rem_in = div_ge ? tdps_pkg::SHOTS_W'(div_trial - {1'b0, div_dsr_ff})
                              : div_trial[tdps_pkg::SHOTS_W-1:0];
   assign div_dq_in  = {div_dq_ff[tdps_pkg::SESS_W-2:0], div_ge};

   // scheduler state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tdps_pkg::MODE_IDLE;
         wait_ff  <= '0;
         pre_ff   <= '0;
         sess_ff  <= tdps_pkg::RST_SESSION_SECONDS;
         intv_ff  <= '0;
         shots_ff <= tdps_pkg::RST_SHOTS_PER_SESSION;
         full_ff  <= 1'b0;
         led_ff   <= 1'b0;
         tog_ff   <= '0;
         pump_ff  <= 1'b0;
      end else if (req_fire) begin
         mode_ff  <= mode_in;
         wait_ff  <= wait_in;
         pre_ff   <= pre_in;
         sess_ff  <= sess_in;
         intv_ff  <= intv_in;
         shots_ff <= shots_in;
         full_ff  <= full_in;
         led_ff   <= led_in;
         tog_ff   <= tog_in;
         pump_ff  <= pump_in;
      end else if (div_busy_ff && div_cnt_ff == CNT_LAST) begin
         // store quotient, less the second that passed on the removal tick
         intv_ff <= div_dq_in - tdps_pkg::SESS_W'(div_dec_ff && div_dq_in != '0);
      end
   end

   // divider control
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (req_fire) begin
         div_busy_ff <= div_start;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (div_cnt_ff == CNT_LAST) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         div_dq_ff  <= sess_ff;
         div_rem_ff <= '0;
         div_dsr_ff <= shots_in;
         div_dec_ff <= div_dec_in;
      end else if (div_busy_ff) begin
         div_dq_ff  <= div_dq_in;
         div_rem_ff <= div_rem_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_led_ff    <= led_in;
         rsp_pump_ff   <= pump_in;
         rsp_asleep_ff <= (mode_in == tdps_pkg::MODE_SLEEP);
         rsp_sess_ff   <= sess_in;
      end
   end

   // checks
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !req_ready)
      else $error("item accepted while divider busy");

   a_pump_only_in_pump_mode: assert property (@(posedge clock) disable iff (reset)
      pump_ff |-> (mode_ff == tdps_pkg::MODE_PUMP))
      else $error("pump running outside pump mode");

   a_divide_on_removal: assert property (@(posedge clock) disable iff (reset)
      $rose(div_busy_ff) |-> (mode_ff == tdps_pkg::MODE_RELEASE))
      else $error("divide started without cup removal");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (div_busy_ff && div_cnt_ff == CNT_LAST) |=> !div_busy_ff)
      else $error("divider did not finish after last step");

endmodule
